/* rtl/core/base19_text_adder_core_macros.svh */
// Assertion macros for the core's RTL files (included by b19ta_back).
`ifndef BASE19_TEXT_ADDER_CORE_MACROS_SVH
`define BASE19_TEXT_ADDER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// cond must hold at every rising clock edge outside reset
`define B19TA_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("b19ta assertion failed");

// ante at an edge implies cons at the same edge
`define B19TA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b19ta assertion failed");

`else

`define B19TA_ASSERT_ALWAYS(label, clk, rst, cond)
`define B19TA_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/b19ta_pkg.sv */
package b19ta_pkg;

   localparam int OPERAND_BITS   = 31;
   localparam int MAX_SUM_DIGITS = 8;
   localparam int SUM_BITS       = OPERAND_BITS + 1;
   localparam int DIGIT_BITS     = 5;
   localparam int CHAR_BITS      = 8;

   localparam logic [DIGIT_BITS-1:0] RADIX      = 5'd19;
   localparam logic [DIGIT_BITS-1:0] DEC_LIMIT  = 5'd10;
   localparam logic [CHAR_BITS-1:0]  CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_BITS-1:0]  CHAR_NINE  = 8'd57;
   localparam logic [CHAR_BITS-1:0]  CHAR_A     = 8'd97;
   localparam logic [CHAR_BITS-1:0]  CHAR_I     = 8'd105;

   // divider consumes this many dividend bits per cycle
   localparam int DIV_STEP_BITS = 8;
   localparam int DIV_STEPS     = (SUM_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
   localparam int DIV_BITS      = DIV_STEPS * DIV_STEP_BITS;
   localparam int STEP_BITS     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   localparam int CNT_BITS = $clog2(MAX_SUM_DIGITS + 1);
   localparam int IDX_BITS = $clog2(MAX_SUM_DIGITS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OPERAND_BITS-1:0] OPERAND_MAX = {OPERAND_BITS{1'b1}};

   typedef struct packed {
      logic [OPERAND_BITS-1:0] first;
      logic [OPERAND_BITS-1:0] second;
      logic                    overflow;
      logic                    invalid;
   } job_type;

   typedef struct packed {
      logic            push;
      job_type         push_job;
   } queue_wr_type;

   typedef struct packed {
      job_type         pop_job;
      logic            empty;
   } queue_rd_type;

   typedef struct packed {
      logic [DIGIT_BITS-1:0] digit;
      logic                  ok;
   } decoded_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_CONVERT,
      BACK_EMIT
   } back_state_type;

   function automatic decoded_type decode_char(input logic [CHAR_BITS-1:0] ch);
      decoded_type res;
      res.digit = '0;
      res.ok    = 1'b0;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         res.digit = DIGIT_BITS'(ch - CHAR_ZERO);
         res.ok    = 1'b1;
      end else if (ch >= CHAR_A && ch <= CHAR_I) begin
         res.digit = DIGIT_BITS'(ch - CHAR_A) + DEC_LIMIT;
         res.ok    = 1'b1;
      end
      return res;
   endfunction

   function automatic logic [CHAR_BITS-1:0] encode_digit(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] res;
      if (d < DEC_LIMIT) begin
         res = CHAR_ZERO + CHAR_BITS'(d);
      end else begin
         res = CHAR_A + CHAR_BITS'(d - DEC_LIMIT);
      end
      return res;
   endfunction

endpackage

/* rtl/core/b19ta_front.sv */
module b19ta_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [b19ta_pkg::CHAR_BITS-1:0]    req_character,
   input  logic                               req_operand_end,
   output b19ta_pkg::queue_wr_type            queue_wr,
   input  logic                               queue_full
);
   import b19ta_pkg::*;

   localparam int WIDE_BITS = OPERAND_BITS + 5;

   logic [OPERAND_BITS-1:0] acc_ff, acc_in;
   logic [OPERAND_BITS-1:0] first_ff, first_in;
   logic                    second_ff, second_in;
   logic                    ovf_ff, ovf_in;
   logic                    inv_ff, inv_in;

   logic                    accept;
   decoded_type             dec;
   logic [WIDE_BITS-1:0]    wide;
   logic                    sat;
   logic [OPERAND_BITS-1:0] acc_new;
   logic                    ovf_now;
   logic                    inv_now;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // acc * 19 + digit, saturate when it leaves the operand range
   always_comb begin
      dec     = decode_char(req_character);
      wide    = {1'b0, acc_ff, 4'b0000} + {4'b0000, acc_ff, 1'b0} + {5'b00000, acc_ff}
              + WIDE_BITS'(dec.digit);
      sat     = |wide[WIDE_BITS-1:OPERAND_BITS];
      acc_new = sat ? OPERAND_MAX : wide[OPERAND_BITS-1:0];
      ovf_now = ovf_ff | sat;
      inv_now = inv_ff | !dec.ok;
   end

   always_comb begin
      acc_in    = acc_ff;
      first_in  = first_ff;
      second_in = second_ff;
      ovf_in    = ovf_ff;
      inv_in    = inv_ff;
      queue_wr.push              = 1'b0;
      queue_wr.push_job.first    = first_ff;
      queue_wr.push_job.second   = acc_new;
      queue_wr.push_job.overflow = ovf_now;
      queue_wr.push_job.invalid  = inv_now;
      if (accept) begin
         priority if (!req_operand_end) begin
            acc_in = acc_new;
            ovf_in = ovf_now;
            inv_in = inv_now;
         end else if (!second_ff) begin
            first_in  = acc_new;
            acc_in    = '0;
            second_in = 1'b1;
            ovf_in    = ovf_now;
            inv_in    = inv_now;
         end else begin
            // pair complete: hand it to the converter and start over
            queue_wr.push = 1'b1;
            acc_in    = '0;
            first_in  = '0;
            second_in = 1'b0;
            ovf_in    = 1'b0;
            inv_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         first_ff  <= '0;
         second_ff <= 1'b0;
         ovf_ff    <= 1'b0;
         inv_ff    <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         ovf_ff    <= ovf_in;
         inv_ff    <= inv_in;
      end
   end

endmodule

/* rtl/core/b19ta_queue.sv */
module b19ta_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  b19ta_pkg::queue_wr_type queue_wr,
   output logic                    queue_full,
   input  logic                    queue_pop,
   output b19ta_pkg::queue_rd_type queue_rd
);
   import b19ta_pkg::*;

   job_type                slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                   do_push;
   logic                   do_pop;

   assign queue_full = (cnt_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign do_push    = queue_wr.push && !queue_full;
   assign do_pop     = queue_pop && (cnt_ff != '0);

   assign queue_rd.pop_job = slot_ff[rd_ptr_ff];
   assign queue_rd.empty   = (cnt_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= queue_wr.push_job;
      end
   end

endmodule

/* rtl/core/b19ta_back.sv */
`include "base19_text_adder_core_macros.svh"

module b19ta_back (
   input  logic                               clock,
   input  logic                               reset,
   input  b19ta_pkg::queue_rd_type            queue_rd,
   output logic                               queue_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [b19ta_pkg::CHAR_BITS-1:0]    rsp_sum_character,
   output logic                               rsp_last_digit,
   output logic                               rsp_overflow,
   output logic                               rsp_invalid
);
   import b19ta_pkg::*;

   back_state_type          state_ff, state_in;
   logic [DIV_BITS-1:0]     work_ff, work_in;
   logic [DIGIT_BITS-1:0]   rem_ff, rem_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic                    ovf_ff, ovf_in;
   logic                    inv_ff, inv_in;
   logic [DIGIT_BITS-1:0]   digits_ff [MAX_SUM_DIGITS];

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]    char_ff, char_in;
   logic                    last_ff, last_in;
   logic                    rovf_ff, rovf_in;
   logic                    rinv_ff, rinv_in;

   logic [DIV_BITS-1:0]     work_step;
   logic [DIGIT_BITS-1:0]   rem_step;
   logic [DIV_STEP_BITS-1:0] quot_bits;
   logic                    step_last;
   logic                    conv_done;
   logic                    digit_wr;
   logic                    out_load;
   logic [IDX_BITS-1:0]     rd_idx;
   logic [SUM_BITS-1:0]     sum;

   assign sum       = SUM_BITS'(queue_rd.pop_job.first) + SUM_BITS'(queue_rd.pop_job.second);
   assign step_last = (step_ff == STEP_BITS'(DIV_STEPS - 1));
   assign rd_idx    = IDX_BITS'(count_ff - 1'b1);
   assign out_load  = (state_ff == BACK_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // restoring division by 19, several dividend bits per cycle; quotient bits
   // shift in at the bottom as dividend bits leave the top
   always_comb begin
      logic [DIGIT_BITS:0] r;
      r         = {1'b0, rem_ff};
      quot_bits = '0;
      for (int i = 0; i < DIV_STEP_BITS; i++) begin
         r = {r[DIGIT_BITS-1:0], work_ff[DIV_BITS-1-i]};
         if (r >= {1'b0, RADIX}) begin
            r = r - {1'b0, RADIX};
            quot_bits[DIV_STEP_BITS-1-i] = 1'b1;
         end
      end
      rem_step  = r[DIGIT_BITS-1:0];
      work_step = {work_ff[DIV_BITS-DIV_STEP_BITS-1:0], quot_bits};
   end

   assign conv_done = (work_step == '0) || (count_ff == CNT_BITS'(MAX_SUM_DIGITS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!queue_rd.empty) begin
               state_in = BACK_CONVERT;
            end
         end
         BACK_CONVERT: begin
            if (step_last && conv_done) begin
               state_in = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (out_load && count_ff == CNT_BITS'(1)) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      queue_pop    = 1'b0;
      work_in      = work_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      inv_in       = inv_ff;
      digit_wr     = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      rovf_in      = rovf_ff;
      rinv_in      = rinv_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         BACK_IDLE: begin
            if (!queue_rd.empty) begin
               queue_pop = 1'b1;
               work_in   = DIV_BITS'(sum);
               rem_in    = '0;
               step_in   = '0;
               count_in  = '0;
               ovf_in    = queue_rd.pop_job.overflow;
               inv_in    = queue_rd.pop_job.invalid;
            end
         end
         BACK_CONVERT: begin
            work_in = work_step;
            if (step_last) begin
               digit_wr = 1'b1;
               count_in = count_ff + 1'b1;
               rem_in   = '0;
               step_in  = '0;
               // sum has more digits than fit: keep the low ones, flag it
               if (conv_done && work_step != '0) begin
                  ovf_in = 1'b1;
               end
            end else begin
               rem_in  = rem_step;
               step_in = step_ff + 1'b1;
            end
         end
         BACK_EMIT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               char_in      = encode_digit(digits_ff[rd_idx]);
               last_in      = (count_ff == CNT_BITS'(1));
               rovf_in      = ovf_ff;
               rinv_in      = inv_ff;
               count_in     = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      ovf_ff  <= ovf_in;
      inv_ff  <= inv_in;
      char_ff <= char_in;
      last_ff <= last_in;
      rovf_ff <= rovf_in;
      rinv_ff <= rinv_in;
      if (digit_wr) begin
         digits_ff[count_ff[IDX_BITS-1:0]] <= rem_step;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sum_character = char_ff;
   assign rsp_last_digit    = last_ff;
   assign rsp_overflow      = rovf_ff;
   assign rsp_invalid       = rinv_ff;

   `B19TA_ASSERT_ALWAYS(a_count_in_range, clock, reset, count_ff <= CNT_BITS'(MAX_SUM_DIGITS))
   `B19TA_ASSERT_IMPLIES(a_emit_has_digits, clock, reset, state_ff == BACK_EMIT, count_ff != '0)
   `B19TA_ASSERT_IMPLIES(a_convert_room, clock, reset, state_ff == BACK_CONVERT, count_ff < CNT_BITS'(MAX_SUM_DIGITS))

endmodule

/* rtl/core/base19_text_adder_core.sv */
// Channel   Handshake                 Payload
// req       req_valid / req_stall     req_character, req_operand_end
// rsp       rsp_valid / rsp_stall     rsp_sum_character, rsp_last_digit,
//                                     rsp_overflow, rsp_invalid
//
// Characters are taken one per cycle while the pair queue has room.
// Each pair is popped from the queue into the divide-by-19 unit, which works out
// the sum digits one by one and handles DIV_STEP_BITS dividend bits a cycle;
// digits then leave at one per cycle from the output register while rsp_stall is low.
// Reset is synchronous and clears all control state; the digit store is not reset.
// req_stall rises only when the two-entry pair queue is full.
module base19_text_adder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_character,
   input  logic       req_operand_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_sum_character,
   output logic       rsp_last_digit,
   output logic       rsp_overflow,
   output logic       rsp_invalid
);
   import b19ta_pkg::*;

   queue_wr_type queue_wr;
   queue_rd_type queue_rd;
   logic         queue_full;
   logic         queue_pop;

   b19ta_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_character   (req_character),
      .req_operand_end (req_operand_end),
      .queue_wr        (queue_wr),
      .queue_full      (queue_full)
   );

   b19ta_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .queue_wr   (queue_wr),
      .queue_full (queue_full),
      .queue_pop  (queue_pop),
      .queue_rd   (queue_rd)
   );

   b19ta_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_rd          (queue_rd),
      .queue_pop         (queue_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sum_character (rsp_sum_character),
      .rsp_last_digit    (rsp_last_digit),
      .rsp_overflow      (rsp_overflow),
      .rsp_invalid       (rsp_invalid)
   );

endmodule

/* tb/base19_text_adder_core_tb.sv */
`timescale 1ns / 1ps

module base19_text_adder_core_tb;
   import b19ta_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 48;
   localparam int RANDOM_CHARS = 225;

   typedef struct {
      logic [7:0] sum_character;
      logic       last_digit;
      logic       overflow;
      logic       invalid;
   } sum_digit_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_character = CHAR_ZERO;
   logic       req_operand_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_sum_character;
   logic       rsp_last_digit;
   logic       rsp_overflow;
   logic       rsp_invalid;

   // adder state as the predictor sees it
   logic [63:0] acc_value = '0;
   logic [63:0] first_value = '0;
   logic        on_second = 1'b0;
   logic        saw_overflow = 1'b0;
   logic        saw_invalid = 1'b0;

   sum_digit_type expected_digits[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          accepted_chars = 0;
   int          hold_off_left = 0;
   int          stall_left = 0;
   bit          no_idle = 1'b0;

   base19_text_adder_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_character     (req_character),
      .req_operand_end   (req_operand_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sum_character (rsp_sum_character),
      .rsp_last_digit    (rsp_last_digit),
      .rsp_overflow      (rsp_overflow),
      .rsp_invalid       (rsp_invalid)
   );

   always #5 clock = ~clock;

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 30);
   endfunction

   function automatic logic [7:0] digit_to_char(input logic [63:0] d);
      if (d < 64'(DEC_LIMIT)) begin
         return CHAR_ZERO + 8'(d);
      end
      return CHAR_A + 8'(d - 64'(DEC_LIMIT));
   endfunction

   // Fold one accepted character into the running operand; on the end of the
   // second operand, queue the sum digits most significant first.
   task automatic predict_sum_digits(input logic [7:0] ch, input logic op_end);
      logic [63:0] d;
      logic [63:0] ceiling;
      logic [63:0] total;
      logic [63:0] digits[MAX_SUM_DIGITS];
      int          n;
      sum_digit_type e;
      ceiling = 64'(OPERAND_MAX);
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         d = 64'(ch - CHAR_ZERO);
      end else if (ch >= CHAR_A && ch <= CHAR_I) begin
         d = 64'(ch - CHAR_A) + 64'(DEC_LIMIT);
      end else begin
         d = '0;
         saw_invalid = 1'b1;
      end
      if (acc_value > (ceiling - d) / 64'(RADIX)) begin
         acc_value = ceiling;
         saw_overflow = 1'b1;
      end else begin
         acc_value = acc_value * 64'(RADIX) + d;
      end
      if (!op_end) begin
         return;
      end
      if (!on_second) begin
         first_value = acc_value;
         acc_value = '0;
         on_second = 1'b1;
         return;
      end
      total = first_value + acc_value;
      n = 0;
      do begin
         digits[n] = total % 64'(RADIX);
         total = total / 64'(RADIX);
         n++;
      end while (total != 0 && n < MAX_SUM_DIGITS);
      if (total != 0) begin
         saw_overflow = 1'b1;
      end
      for (int k = 0; k < n; k++) begin
         e.sum_character = digit_to_char(digits[n - 1 - k]);
         e.last_digit = (k == n - 1);
         e.overflow = saw_overflow;
         e.invalid = saw_invalid;
         expected_digits.push_back(e);
      end
      acc_value = '0;
      first_value = '0;
      on_second = 1'b0;
      saw_overflow = 1'b0;
      saw_invalid = 1'b0;
   endtask

   // Offer one character and hold it until the transaction completes.
   task automatic send_char(input logic [7:0] ch, input logic op_end);
      int gap;
      gap = (no_idle || $urandom_range(0, 99) < 60) ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_character <= ch;
      req_operand_end <= op_end;
      do @(posedge clock); while (req_stall);
      accepted_chars++;
      predict_sum_digits(ch, op_end);
   endtask

   task automatic send_number(input string text);
      for (int i = 0; i < text.len(); i++) begin
         send_char(text[i], i == text.len() - 1);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_zero_sum();
      send_number("0");
      send_number("0");
   endtask

   task automatic test_saturation();
      send_number("iiiiiiii");
      send_number("iiiiiiii");
   endtask

   task automatic test_invalid_chars();
      send_char(8'h2f, 1'b0);
      send_char(8'hff, 1'b1);
      send_char(8'h00, 1'b0);
      send_char(8'h6a, 1'b1);
   endtask

   task automatic test_leading_zeros_carry();
      send_number("00i");
      send_number("1");
   endtask

   // Hold the result side off while pairs keep arriving, so the pair queue
   // fills and the input stalls.
   task automatic test_backpressure();
      no_idle = 1'b1;
      hold_off_left = 300;
      for (int i = 0; i < 8; i++) begin
         send_number("5");
         send_number("h7");
      end
      no_idle = 1'b0;
      wait_for_drain();
   endtask

   task automatic send_random_operand();
      int          len;
      logic [7:0]  ch;
      logic [63:0] v;
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 5) : $urandom_range(6, 9);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 92) begin
            v = 64'($urandom_range(0, 18));
            ch = digit_to_char(v);
         end else begin
            ch = 8'($urandom_range(0, 255));
         end
         send_char(ch, i == len - 1);
      end
   endtask

   task automatic test_random_pairs();
      int start;
      start = accepted_chars;
      while (accepted_chars - start < RANDOM_CHARS) begin
         if ($urandom_range(0, 99) < 10) begin
            no_idle = ~no_idle;
         end
         send_random_operand();
         // a stray byte with the end flag set makes some second operands a single random character
         if ($urandom_range(0, 99) < 5) begin
            send_char(8'($urandom_range(0, 255)), 1'b1);
         end else begin
            send_random_operand();
         end
         if ($urandom_range(0, 99) < 6) begin
            wait_for_drain();
         end
      end
      no_idle = 1'b0;
      wait_for_drain();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left--;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (!no_idle && $urandom_range(0, 99) < 25) begin
         stall_left = idle_len() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : check_sum
      sum_digit_type e;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (expected_digits.size() == 0) begin
            $display("%0t: sum digit expected none got %0h last %0b ovf %0b inv %0b",
                     $time, rsp_sum_character, rsp_last_digit, rsp_overflow, rsp_invalid);
            error_count++;
         end else begin
            e = expected_digits.pop_front();
            check_field("sum_character", e.sum_character, rsp_sum_character);
            check_field("last_digit", 8'(e.last_digit), 8'(rsp_last_digit));
            check_field("overflow", 8'(e.overflow), 8'(rsp_overflow));
            check_field("invalid", 8'(e.invalid), 8'(rsp_invalid));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[base19_text_adder_core] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zero_sum();
      test_saturation();
      test_invalid_chars();
      test_leading_zeros_carry();
      wait_for_drain();
      test_backpressure();
      test_random_pairs();
      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_digits.size() == 0) begin
         $display("[base19_text_adder_core] OK");
      end else begin
         $display("[base19_text_adder_core] ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/b19ta_pkg.sv
rtl/core/b19ta_front.sv
rtl/core/b19ta_queue.sv
rtl/core/b19ta_back.sv
rtl/core/base19_text_adder_core.sv
tb/base19_text_adder_core_tb.sv
